FILE: rtl/core/opc_pkg.sv
// Shared constants, widths and types of the omnidirectional position controller.
// No dependencies; every other file of the block imports this package.
package opc_pkg;

  localparam int ANGLE_BITS     = 16;
  localparam int TRIG_FRAC_BITS = 15;

  localparam int DW  = 16;
  localparam int LW  = 15;
  localparam int EW  = DW + 1;
  localparam int CW  = 33;
  localparam int TW  = TRIG_FRAC_BITS + 3;
  localparam int PW  = EW + TW;
  localparam int RW  = PW + 1;
  localparam int GW  = RW + 17;

  localparam int CORDIC_ITERS = 30;
  localparam int CORDIC_FRAC  = 30;
  localparam int CORDIC_X0    = 652032874;
  localparam int TRIG_SHIFT   = CORDIC_FRAC - TRIG_FRAC_BITS;
  localparam int OUT_SHIFT    = TRIG_FRAC_BITS + 16;
  localparam int VW           = GW - OUT_SHIFT;

  localparam logic [31:0] ANGLE_MASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);

  localparam logic [1:0] REG_GOAL_X = 2'd0;
  localparam logic [1:0] REG_GOAL_Y = 2'd1;
  localparam logic [1:0] REG_GAIN   = 2'd2;
  localparam logic [1:0] REG_LIMIT  = 2'd3;

  localparam logic [31:0] ATAN_TURN [CORDIC_ITERS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  typedef struct packed {
    logic signed [EW-1:0] ex;
    logic signed [EW-1:0] ey;
  } err_t;

endpackage

FILE: rtl/core/opc_if.sv
// Channel interfaces of the controller: pose items in, velocity items out.
// Depends on opc_pkg for the field widths.
interface opc_pose_if import opc_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] pose_x_mm;
  logic signed [DW-1:0] pose_y_mm;
  logic signed [DW-1:0] heading;

  modport source(output valid, pose_x_mm, pose_y_mm, heading, input ready);
  modport sink(input valid, pose_x_mm, pose_y_mm, heading, output ready);
endinterface

interface opc_vel_if import opc_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] vel_forward;
  logic signed [DW-1:0] vel_lateral;

  modport source(output valid, vel_forward, vel_lateral, input ready);
  modport sink(input valid, vel_forward, vel_lateral, output ready);
endinterface

FILE: rtl/core/opc_cordic.sv
// Pipelined CORDIC rotator, one iteration per stage, giving cosine and sine of the heading.
// Depends on opc_pkg; the position error rides along with each item.
module opc_cordic import opc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [1:0]           in_quad,
  input  logic signed [CW-1:0] in_angle,
  input  err_t                 in_err,
  output logic                 out_valid,
  output logic signed [TW-1:0] cos_q,
  output logic signed [TW-1:0] sin_q,
  output err_t                 out_err
);

  localparam logic signed [CW-1:0] TRIG_HALF = CW'(1) <<< (TRIG_SHIFT - 1);

  logic signed [CW-1:0] x_s [CORDIC_ITERS];
  logic signed [CW-1:0] y_s [CORDIC_ITERS];
  logic signed [CW-1:0] z_s [CORDIC_ITERS];
  logic                 v_s [CORDIC_ITERS];
  logic [1:0]           q_s [CORDIC_ITERS];
  err_t                 e_s [CORDIC_ITERS];

  for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_iter
    localparam logic signed [CW-1:0] ATAN_I = CW'(ATAN_TURN[i]);
    logic signed [CW-1:0] xp, yp, zp;
    logic                 vp;
    logic [1:0]           qp;
    err_t                 ep;
    logic signed [CW-1:0] xsh, ysh;

    if (i == 0) begin : g_first
      assign xp = CW'(CORDIC_X0);
      assign yp = '0;
      assign zp = in_angle;
      assign vp = in_valid;
      assign qp = in_quad;
      assign ep = in_err;
    end else begin : g_rest
      assign xp = x_s[i-1];
      assign yp = y_s[i-1];
      assign zp = z_s[i-1];
      assign vp = v_s[i-1];
      assign qp = q_s[i-1];
      assign ep = e_s[i-1];
    end

    assign xsh = xp >>> i;
    assign ysh = yp >>> i;

    always_ff @(posedge clk) begin
      if (rst) begin
        v_s[i] <= 1'b0;
      end else if (en) begin
        v_s[i] <= vp;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_s[i] <= qp;
        e_s[i] <= ep;
        if (!zp[CW-1]) begin
          x_s[i] <= xp - ysh;
          y_s[i] <= yp + xsh;
          z_s[i] <= zp - ATAN_I;
        end else begin
          x_s[i] <= xp + ysh;
          y_s[i] <= yp - xsh;
          z_s[i] <= zp + ATAN_I;
        end
      end
    end
  end

  logic signed [CW-1:0] x_rnd, y_rnd;
  logic signed [TW-1:0] c_r, s_r;

  assign x_rnd = (x_s[CORDIC_ITERS-1] + TRIG_HALF) >>> TRIG_SHIFT;
  assign y_rnd = (y_s[CORDIC_ITERS-1] + TRIG_HALF) >>> TRIG_SHIFT;
  assign c_r   = x_rnd[TW-1:0];
  assign s_r   = y_rnd[TW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v_s[CORDIC_ITERS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_err <= e_s[CORDIC_ITERS-1];
      case (q_s[CORDIC_ITERS-1])
        2'd0: begin
          cos_q <= c_r;
          sin_q <= s_r;
        end
        2'd1: begin
          cos_q <= -s_r;
          sin_q <= c_r;
        end
        2'd2: begin
          cos_q <= -c_r;
          sin_q <= -s_r;
        end
        default: begin
          cos_q <= s_r;
          sin_q <= -c_r;
        end
      endcase
    end
  end

endmodule

FILE: rtl/core/opc_scale.sv
// Rotation products, gain scaling, rounding and two-sided clamping in five stages.
// Depends on opc_pkg; fed by opc_cordic.
module opc_scale import opc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [TW-1:0] cos_q,
  input  logic signed [TW-1:0] sin_q,
  input  err_t                 in_err,
  input  logic [DW-1:0]        gain,
  input  logic [LW-1:0]        limit,
  output logic                 out_valid,
  output logic signed [DW-1:0] vel_fwd,
  output logic signed [DW-1:0] vel_lat
);

  localparam logic signed [GW-1:0] OUT_HALF = GW'(1) <<< (OUT_SHIFT - 1);

  logic [4:0] v;

  logic signed [PW-1:0] p_xc, p_ys, p_xs, p_yc;
  logic signed [RW-1:0] sum_f, sum_l;
  logic signed [GW-1:0] g_f, g_l;
  logic signed [VW-1:0] r_f, r_l;

  logic signed [16:0]   gain_s;
  logic signed [GW-1:0] g_f_rnd, g_l_rnd;
  logic signed [VW-1:0] lim_p, lim_n, c_f, c_l;

  function automatic logic signed [VW-1:0] clamp(
    input logic signed [VW-1:0] val,
    input logic signed [VW-1:0] hi,
    input logic signed [VW-1:0] lo
  );
    logic signed [VW-1:0] res;
    res = val;
    if (val > hi) begin
      res = hi;
    end
    if (val < lo) begin
      res = lo;
    end
    return res;
  endfunction

  assign gain_s  = $signed({1'b0, gain});
  assign g_f_rnd = (g_f + OUT_HALF) >>> OUT_SHIFT;
  assign g_l_rnd = (g_l + OUT_HALF) >>> OUT_SHIFT;
  assign lim_p   = $signed(VW'(limit));
  assign lim_n   = -lim_p;
  assign c_f     = clamp(r_f, lim_p, lim_n);
  assign c_l     = clamp(r_l, lim_p, lim_n);

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_xc    <= $signed(in_err.ex) * cos_q;
      p_ys    <= $signed(in_err.ey) * sin_q;
      p_xs    <= $signed(in_err.ex) * sin_q;
      p_yc    <= $signed(in_err.ey) * cos_q;
      sum_f   <= RW'(p_xc) + RW'(p_ys);
      sum_l   <= RW'(p_yc) - RW'(p_xs);
      g_f     <= sum_f * gain_s;
      g_l     <= sum_l * gain_s;
      r_f     <= g_f_rnd[VW-1:0];
      r_l     <= g_l_rnd[VW-1:0];
      vel_fwd <= c_f[DW-1:0];
      vel_lat <= c_l[DW-1:0];
    end
  end

  assign out_valid = v[4];

endmodule

FILE: rtl/core/omni_position_p_controller_unit.sv
// Top level of the omnidirectional proportional position controller.
// Depends on opc_pkg, opc_if, opc_cordic and opc_scale.
//
//   Channel  Dir  Handshake    Payload
//   pose     in   valid/ready  pose_x_mm, pose_y_mm, heading
//   vel      out  valid/ready  vel_forward, vel_lateral
//   cfg      in   cfg_we       cfg_index, cfg_data
//
// One item enters per cycle unless the output stalls; the stages are one error stage,
// thirty CORDIC iteration stages, one trig rounding stage and five scaling stages.
// Reset clears the valid bits of every stage and loads the register defaults.
// While a result waits on the output the whole pipeline holds in place.
module omni_position_p_controller_unit import opc_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [DW-1:0] cfg_data,
  opc_pose_if.sink      pose,
  opc_vel_if.source     vel
);

  localparam logic signed [TW-1:0] TRIG_MAX = (TW'(1) <<< TRIG_FRAC_BITS) + TW'(2);

  logic signed [DW-1:0] goal_x;
  logic signed [DW-1:0] goal_y;
  logic [DW-1:0]        gain;
  logic [LW-1:0]        speed_limit;

  logic                 en;
  logic [31:0]          phase;
  logic                 e_valid;
  logic [1:0]           e_quad;
  logic signed [CW-1:0] e_angle;
  err_t                 e_err;

  logic                 c_valid;
  logic signed [TW-1:0] cos_q, sin_q;
  err_t                 c_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      goal_x      <= '0;
      goal_y      <= '0;
      gain        <= DW'(3277);
      speed_limit <= LW'(500);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GOAL_X: goal_x      <= cfg_data;
        REG_GOAL_Y: goal_y      <= cfg_data;
        REG_GAIN:   gain        <= cfg_data;
        REG_LIMIT:  speed_limit <= cfg_data[LW-1:0];
        default: ;
      endcase
    end
  end

  assign en         = !vel.valid || vel.ready;
  assign pose.ready = en && !rst;
  assign phase      = {pose.heading, 16'b0} & ANGLE_MASK;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (en) begin
      e_valid <= pose.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_quad   <= phase[31:30];
      e_angle  <= CW'(phase[29:0]);
      e_err.ex <= EW'(goal_x) - EW'(pose.pose_x_mm);
      e_err.ey <= EW'(goal_y) - EW'(pose.pose_y_mm);
    end
  end

  opc_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (e_valid),
    .in_quad   (e_quad),
    .in_angle  (e_angle),
    .in_err    (e_err),
    .out_valid (c_valid),
    .cos_q     (cos_q),
    .sin_q     (sin_q),
    .out_err   (c_err)
  );

  opc_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (c_valid),
    .cos_q     (cos_q),
    .sin_q     (sin_q),
    .in_err    (c_err),
    .gain      (gain),
    .limit     (speed_limit),
    .out_valid (vel.valid),
    .vel_fwd   (vel.vel_forward),
    .vel_lat   (vel.vel_lateral)
  );

  // A delivered velocity never exceeds the configured limit in either direction.
  a_clamp: assert property (@(posedge clk) disable iff (rst)
    vel.valid |-> ($signed(vel.vel_forward) <= $signed({1'b0, speed_limit}))
               && ($signed(vel.vel_forward) >= -$signed({1'b0, speed_limit}))
               && ($signed(vel.vel_lateral) <= $signed({1'b0, speed_limit}))
               && ($signed(vel.vel_lateral) >= -$signed({1'b0, speed_limit})))
    else $error("velocity outside the speed limit");

  // The rotator output stays within unit magnitude plus rounding.
  a_trig: assert property (@(posedge clk) disable iff (rst)
    c_valid |-> (cos_q <= TRIG_MAX) && (cos_q >= -TRIG_MAX)
             && (sin_q <= TRIG_MAX) && (sin_q >= -TRIG_MAX))
    else $error("cosine or sine out of range");

endmodule

FILE: bench/omni_position_p_controller_unit_tb.sv
// Testbench of the omnidirectional position controller: pose items in, velocity items out.
// Each result is checked against a bit-exact predictor with its own CORDIC and clamp.
// Depends on opc_pkg, opc_if and the controller RTL.
module omni_position_p_controller_unit_tb import opc_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [15:0] fwd;
    logic signed [15:0] lat;
  } vel_t;

  localparam longint ARCTAN_STEP [30] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };
  localparam longint ROTATOR_X0 = 652032874;
  localparam int DRAIN_CYCLES = 60;

  logic          clk;
  logic          rst;
  logic          cfg_we;
  logic [1:0]    cfg_index;
  logic [DW-1:0] cfg_data;

  opc_pose_if pose_ch();
  opc_vel_if  vel_ch();

  omni_position_p_controller_unit DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .pose(pose_ch),
    .vel(vel_ch)
  );

  logic signed [15:0] goal_x;
  logic signed [15:0] goal_y;
  logic [15:0]        gain;
  logic [14:0]        limit;

  vel_t expected_vel[$];
  int   mismatches;
  int   n_poses;
  int   n_velocities;
  int   n_settings;
  int   hold_left;
  bit   quiet_in;
  bit   quiet_out;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic longint round_off(input longint v, input int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  task automatic heading_trig(input logic signed [15:0] hd, output longint c, output longint s);
    logic [31:0] phase;
    longint      x;
    longint      y;
    longint      z;
    longint      nx;
    longint      rc;
    longint      rs;
    phase = {hd, 16'h0000} & ANGLE_MASK;
    x = ROTATOR_X0;
    y = 0;
    z = longint'(phase[29:0]);
    for (int i = 0; i < 30; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - ARCTAN_STEP[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + ARCTAN_STEP[i];
      end
      x = nx;
    end
    rc = round_off(x, 30 - TRIG_FRAC_BITS);
    rs = round_off(y, 30 - TRIG_FRAC_BITS);
    case (phase[31:30])
      2'd0: begin c = rc;  s = rs;  end
      2'd1: begin c = -rs; s = rc;  end
      2'd2: begin c = -rc; s = -rs; end
      default: begin c = rs; s = -rc; end
    endcase
  endtask

  function automatic logic signed [15:0] scale_clamp(input longint rotated);
    longint v;
    longint lim;
    lim = longint'(limit);
    v = round_off(rotated * longint'(gain), TRIG_FRAC_BITS + 16);
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    return v[15:0];
  endfunction

  task automatic predict_velocity(input logic signed [15:0] px, input logic signed [15:0] py,
                                  input logic signed [15:0] hd, output vel_t v);
    longint ex;
    longint ey;
    longint c;
    longint s;
    ex = longint'(goal_x) - longint'(px);
    ey = longint'(goal_y) - longint'(py);
    heading_trig(hd, c, s);
    v.fwd = scale_clamp(ex * c + ey * s);
    v.lat = scale_clamp(-ex * s + ey * c);
  endtask

  // Velocity side: ready with random stalls or a long hold-off, and the result check.
  always @(posedge clk) begin
    vel_t want;
    if (rst) begin
      vel_ch.ready <= 1'b0;
    end else begin
      if (vel_ch.valid && vel_ch.ready) begin
        n_velocities++;
        if (expected_vel.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Unexpected velocity item fwd=%0d lat=%0d", vel_ch.vel_forward,
                     vel_ch.vel_lateral);
        end else begin
          want = expected_vel.pop_front();
          if (vel_ch.vel_forward !== want.fwd || vel_ch.vel_lateral !== want.lat) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Velocity mismatch: expected fwd=%0d lat=%0d, got fwd=%0d lat=%0d",
                       want.fwd, want.lat, vel_ch.vel_forward, vel_ch.vel_lateral);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        vel_ch.ready <= 1'b0;
      end else begin
        vel_ch.ready <= quiet_out || ($urandom_range(99) >= 6);
      end
    end
  end

  task automatic send_pose(input logic signed [15:0] px, input logic signed [15:0] py,
                           input logic signed [15:0] hd);
    vel_t v;
    if (!quiet_in) begin
      while ($urandom_range(99) < 6) begin
        pose_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    pose_ch.valid     <= 1'b1;
    pose_ch.pose_x_mm <= px;
    pose_ch.pose_y_mm <= py;
    pose_ch.heading   <= hd;
    do @(posedge clk); while (!pose_ch.ready);
    predict_velocity(px, py, hd, v);
    expected_vel.push_back(v);
    n_poses++;
  endtask

  task automatic drain;
    pose_ch.valid <= 1'b0;
    while (expected_vel.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_regs(input logic [15:0] gx, input logic [15:0] gy,
                          input logic [15:0] k, input logic [15:0] lim);
    logic [15:0] vals [4];
    logic [1:0]  idx [4];
    vals = '{gx, gy, k, lim};
    idx  = '{REG_GOAL_X, REG_GOAL_Y, REG_GAIN, REG_LIMIT};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    goal_x = gx;
    goal_y = gy;
    gain   = k;
    limit  = lim[14:0];
    n_settings++;
  endtask

  function automatic logic [15:0] pick_edge();
    case ($urandom_range(3))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      default: return 16'hFFFF;
    endcase
  endfunction

  task automatic test_reset_defaults;
    send_pose(16'sd0, 16'sd0, 16'sd0);
    send_pose(16'sd1000, -16'sd2000, 16'sd8192);
    send_pose(16'sd40, 16'sd0, 16'sd0);
    send_pose(-16'sd32768, 16'sd32767, -16'sd16384);
    drain();
  endtask

  task automatic test_extremes;
    set_regs(16'h7FFF, 16'h8000, 16'hFFFF, 16'h7FFF);
    send_pose(-16'sd32768, 16'sd32767, 16'sd0);
    send_pose(16'sd32767, -16'sd32768, 16'sd16384);
    send_pose(16'sd32767, 16'sd32767, -16'sd32768);
    send_pose(-16'sd32768, -16'sd32768, -16'sd16384);
    send_pose(16'sd32700, -16'sd32700, 16'sd32767);
    send_pose(16'sd32767, -16'sd32768, -16'sd1);
    send_pose(16'sd32760, -16'sd32760, 16'sd1);
    drain();
    set_regs(16'h0064, 16'hFF38, 16'h8000, 16'hFFFF);
    send_pose(16'sd99, -16'sd201, 16'sd4096);
    send_pose(16'sd101, -16'sd199, 16'sd12288);
    send_pose(16'sd0, 16'sd0, -16'sd8192);
    drain();
    set_regs(16'h1234, 16'hEDCB, 16'h0000, 16'h7FFF);
    send_pose(-16'sd32768, 16'sd32767, 16'sd5000);
    send_pose(16'sd0, 16'sd0, 16'sd0);
    drain();
    set_regs(16'h7FFF, 16'h8000, 16'hFFFF, 16'h8000);
    send_pose(-16'sd32768, 16'sd32767, 16'sd0);
    send_pose(16'sd0, 16'sd0, 16'sd20000);
    drain();
  endtask

  task automatic test_random_phases(input int phases, input int per_phase);
    logic [15:0] gx;
    logic [15:0] gy;
    logic [15:0] k;
    logic [15:0] lim;
    logic [15:0] px;
    logic [15:0] py;
    int          spread;
    for (int ph = 0; ph < phases; ph++) begin
      gx = ($urandom_range(3) == 0) ? pick_edge() : 16'($urandom);
      gy = ($urandom_range(3) == 0) ? pick_edge() : 16'($urandom);
      case ($urandom_range(5))
        0: k = 16'hFFFF;
        1: k = 16'd3277;
        2: k = ($urandom_range(1) == 0) ? 16'h0000 : 16'h0001;
        default: k = 16'($urandom);
      endcase
      case ($urandom_range(5))
        0: lim = 16'h7FFF;
        1: lim = 16'($urandom_range(3));
        2: lim = 16'($urandom);
        3: lim = 16'hFFFF;
        default: lim = 16'($urandom_range(32767, 1000));
      endcase
      set_regs(gx, gy, k, lim);
      quiet_in  = (ph == 2);
      quiet_out = (ph == 2);
      for (int i = 0; i < per_phase; i++) begin
        case ($urandom_range(9))
          0, 1, 2, 3: begin
            px = 16'($urandom);
            py = 16'($urandom);
          end
          9: begin
            px = pick_edge();
            py = pick_edge();
          end
          default: begin
            case ($urandom_range(2))
              0: spread = 15;
              1: spread = 255;
              default: spread = 4095;
            endcase
            px = gx + 16'($urandom_range(2 * spread) - spread);
            py = gy + 16'($urandom_range(2 * spread) - spread);
          end
        endcase
        send_pose(px, py, 16'($urandom));
      end
      quiet_in  = 1'b0;
      quiet_out = 1'b0;
      drain();
    end
  endtask

  task automatic test_backpressure;
    quiet_in  = 1'b1;
    hold_left = 300;
    for (int i = 0; i < 120; i++)
      send_pose(16'($urandom), 16'($urandom), 16'($urandom));
    quiet_in = 1'b0;
    drain();
  endtask

  task automatic test_pause_mid_stream;
    for (int i = 0; i < 40; i++)
      send_pose(16'($urandom_range(2000) - 1000), 16'($urandom_range(2000) - 1000),
                16'($urandom));
    drain();
    for (int i = 0; i < 40; i++)
      send_pose(16'($urandom), 16'($urandom), 16'($urandom));
    drain();
  endtask

  initial begin
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_index         = REG_GOAL_X;
    cfg_data          = '0;
    pose_ch.valid     = 1'b0;
    pose_ch.pose_x_mm = '0;
    pose_ch.pose_y_mm = '0;
    pose_ch.heading   = '0;
    vel_ch.ready      = 1'b0;
    goal_x            = 16'sd0;
    goal_y            = 16'sd0;
    gain              = 16'd3277;
    limit             = 15'd500;
    mismatches        = 0;
    n_poses           = 0;
    n_velocities      = 0;
    n_settings        = 1;
    hold_left         = 0;
    quiet_in          = 1'b0;
    quiet_out         = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_extremes();
    test_backpressure();
    test_pause_mid_stream();
    test_random_phases(12, 125);

    if (expected_vel.size() != 0) mismatches += expected_vel.size();
    $display("Run covered %0d pose items, %0d velocity items, %0d register settings.",
             n_poses, n_velocities, n_settings);
    $display("Mismatches and missing or extra items: %0d.", mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
